>>> rtl/core/erls_pkg.sv
package erls_pkg;

   localparam int MAX_EDGE_DEF  = 4096;
   localparam int FRAC_BITS_DEF = 16;

   localparam int CNT_W  = 25;
   localparam int SUM_W  = 46;
   localparam int LUMA_W = 22;
   localparam int FRAC_W = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RX   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_RY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIT_TH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EXCESS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKLIT  = 3'd6;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       end_of_line;
      logic       end_of_frame;
   } req_type;

   typedef struct packed {
      logic              measured;
      logic [CNT_W-1:0]  subject_pixels;
      logic [CNT_W-1:0]  backdrop_pixels;
      logic [LUMA_W-1:0] subject_mean;
      logic [LUMA_W-1:0] subject_max;
      logic [FRAC_W-1:0] subject_unlit_frac;
      logic [LUMA_W-1:0] backdrop_mean;
      logic [FRAC_W-1:0] backdrop_unlit_frac;
      logic              silhouette;
   } rsp_type;

   // frame totals handed from front to back
   typedef struct packed {
      logic [CNT_W-1:0]  in_cnt;
      logic [CNT_W-1:0]  out_cnt;
      logic [SUM_W-1:0]  in_sum;
      logic [SUM_W-1:0]  out_sum;
      logic [LUMA_W-1:0] in_peak;
      logic [CNT_W-1:0]  in_unlit;
      logic [CNT_W-1:0]  out_unlit;
   } totals_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_DIV, BK_DONE
   } back_state_type;

endpackage

>>> rtl/core/erls_front.sv
module erls_front #(
   parameter int MAX_EDGE  = erls_pkg::MAX_EDGE_DEF,
   parameter int FRAC_BITS = erls_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  erls_pkg::req_type    req_data,
   input  logic signed [21:0]   center_x,
   input  logic signed [21:0]   center_y,
   input  logic [23:0]          inv_rx,
   input  logic [23:0]          inv_ry,
   input  logic [21:0]          lit_th,
   output logic                 tot_valid,
   input  logic                 tot_ready,
   output erls_pkg::totals_type tot_data
);
   localparam int POS_W = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
   localparam int D_W   = POS_W + 10;
   localparam int PROD_W = 33;
   localparam int T_W   = FRAC_BITS + 1;
   localparam int SQ_W  = 2 * T_W + 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_EDGE - 1);
   localparam logic [PROD_W-1:0] ONE_Q32 = PROD_W'(64'h1_0000_0000);
   localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);
   localparam logic [erls_pkg::CNT_W-1:0] CNT_MAX = '1;
   localparam logic [erls_pkg::SUM_W-1:0] SUM_MAX = '1;

   // stage 1: luma and offset products
   logic              s1_ff, s1_eof_ff, s1_unlit_ff, s1_ovx_ff, s1_ovy_ff;
   logic [21:0]       s1_luma_ff;
   logic [PROD_W-1:0] s1_ox_ff, s1_oy_ff;
   // stage 2: squares
   logic              s2_ff, s2_eof_ff, s2_unlit_ff, s2_out_ff;
   logic [21:0]       s2_luma_ff;
   logic [SQ_W-1:0]   s2_sx_ff, s2_sy_ff;
   logic [POS_W-1:0]  col_ff, row_ff;
   erls_pkg::totals_type acc_ff;
   logic              hold_ff;
   logic              in_ellipse;
   logic [D_W-1:0]    mx, my;
   logic [47:0]       px, py;
   logic [T_W-1:0]    tx, ty;
   logic [21:0]       luma_in;

   // a finished frame's totals sit in the holding slot until taken; an end_of_frame
   // still in the pipe also holds input so a second one never finds the slot full
   assign req_ready = !(hold_ff && !tot_ready) && !(s1_ff && s1_eof_ff) &&
                      !(s2_ff && s2_eof_ff);
   wire take = req_valid && req_ready;

   always_comb begin
      logic signed [D_W:0] dx, dy;
      dx = $signed({1'b0, col_ff, 8'h80}) - (D_W+1)'(center_x);
      dy = $signed({1'b0, row_ff, 8'h80}) - (D_W+1)'(center_y);
      mx = dx[D_W] ? D_W'(-dx) : D_W'(dx);
      my = dy[D_W] ? D_W'(-dy) : D_W'(dy);
      px = 48'(mx) * 48'(inv_rx);
      py = 48'(my) * 48'(inv_ry);
      luma_in = 22'(req_data.red) * 22'd2126 + 22'(req_data.green) * 22'd7152
              + 22'(req_data.blue) * 22'd722;
      tx = T_W'(s1_ox_ff >> (32 - FRAC_BITS));
      ty = T_W'(s1_oy_ff >> (32 - FRAC_BITS));
      in_ellipse = !s2_out_ff && (s2_sx_ff + s2_sy_ff <= ONE_SQ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0; s2_ff <= 1'b0; hold_ff <= 1'b0;
         col_ff <= '0; row_ff <= '0; acc_ff <= '0;
      end else begin
         s1_ff <= take;
         s2_ff <= s1_ff;
         if (take) begin
            if (req_data.end_of_frame) begin
               col_ff <= '0; row_ff <= '0;
            end else if (req_data.end_of_line) begin
               col_ff <= '0;
               if (row_ff != POS_LAST) row_ff <= row_ff + 1'b1;
            end else if (col_ff != POS_LAST) begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (s2_ff && s2_eof_ff) hold_ff <= 1'b1;
         else if (tot_ready)     hold_ff <= 1'b0;
         if (s2_ff) begin
            erls_pkg::totals_type a;
            logic [erls_pkg::SUM_W:0] sum;
            a = acc_ff;
            if (in_ellipse) begin
               if (a.in_cnt != CNT_MAX) a.in_cnt = a.in_cnt + 1'b1;
               sum = {1'b0, a.in_sum} + (erls_pkg::SUM_W+1)'(s2_luma_ff);
               a.in_sum = sum[erls_pkg::SUM_W] ? SUM_MAX : sum[erls_pkg::SUM_W-1:0];
               if (s2_luma_ff > a.in_peak) a.in_peak = s2_luma_ff;
               if (s2_unlit_ff && a.in_unlit != CNT_MAX) a.in_unlit = a.in_unlit + 1'b1;
            end else begin
               if (a.out_cnt != CNT_MAX) a.out_cnt = a.out_cnt + 1'b1;
               sum = {1'b0, a.out_sum} + (erls_pkg::SUM_W+1)'(s2_luma_ff);
               a.out_sum = sum[erls_pkg::SUM_W] ? SUM_MAX : sum[erls_pkg::SUM_W-1:0];
               if (s2_unlit_ff && a.out_unlit != CNT_MAX)
                  a.out_unlit = a.out_unlit + 1'b1;
            end
            if (s2_eof_ff) begin
               tot_data <= a;
               acc_ff   <= '0;
            end else begin
               acc_ff <= a;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_luma_ff  <= luma_in;
      s1_eof_ff   <= req_data.end_of_frame;
      s1_unlit_ff <= luma_in <= lit_th;
      s1_ox_ff    <= PROD_W'(px);
      s1_oy_ff    <= PROD_W'(py);
      s1_ovx_ff   <= px > 48'(ONE_Q32);
      s1_ovy_ff   <= py > 48'(ONE_Q32);
      s2_luma_ff  <= s1_luma_ff;
      s2_eof_ff   <= s1_eof_ff;
      s2_unlit_ff <= s1_unlit_ff;
      s2_out_ff   <= s1_ovx_ff || s1_ovy_ff;
      s2_sx_ff    <= SQ_W'(tx) * SQ_W'(tx);
      s2_sy_ff    <= SQ_W'(ty) * SQ_W'(ty);
   end

   assign tot_valid = hold_ff;
endmodule

>>> rtl/core/erls_div.sv
module erls_div #(
   parameter int NUM_W = 46,
   parameter int DEN_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int CW = $clog2(NUM_W + 1);
   logic [CW-1:0]    cnt_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W:0]   r_ff;
   logic [DEN_W-1:0] d_ff;
   logic [DEN_W:0]   r_in;
   logic             ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      r_in = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      ge   = r_in >= {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CW'(NUM_W);
         q_ff   <= num;
         r_ff   <= '0;
         d_ff   <= den;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         r_ff   <= ge ? r_in - {1'b0, d_ff} : r_in;
         q_ff   <= {q_ff[NUM_W-2:0], ge};
      end
   end

   assign busy = cnt_ff != '0;
   assign quot = q_ff;
endmodule

>>> rtl/core/erls_back.sv
module erls_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tot_valid,
   output logic                 tot_ready,
   input  erls_pkg::totals_type tot_data,
   input  logic [16:0]          excess_share,
   input  logic [16:0]          backlit_share,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output erls_pkg::rsp_type    rsp_data
);
   localparam int NW = erls_pkg::SUM_W;
   localparam int CW = erls_pkg::CNT_W;

   erls_pkg::back_state_type state_ff, state_in;
   erls_pkg::totals_type     t_ff;
   logic                     meas_ff;
   logic                     start;
   logic [3:0]               busy;
   logic [NW-1:0]            q0, q1, q2, q3;
   logic [NW-1:0]            n2, n3;

   assign n2 = NW'({t_ff.in_unlit, 16'h0});
   assign n3 = NW'({t_ff.out_unlit, 16'h0});

   erls_div #(.NUM_W(NW), .DEN_W(CW)) u_d0 (.clock, .reset, .start,
      .num(t_ff.in_sum), .den(t_ff.in_cnt), .busy(busy[0]), .quot(q0));
   erls_div #(.NUM_W(NW), .DEN_W(CW)) u_d1 (.clock, .reset, .start,
      .num(t_ff.out_sum), .den(t_ff.out_cnt), .busy(busy[1]), .quot(q1));
   erls_div #(.NUM_W(NW), .DEN_W(CW)) u_d2 (.clock, .reset, .start,
      .num(n2), .den(t_ff.in_cnt), .busy(busy[2]), .quot(q2));
   erls_div #(.NUM_W(NW), .DEN_W(CW)) u_d3 (.clock, .reset, .start,
      .num(n3), .den(t_ff.out_cnt), .busy(busy[3]), .quot(q3));

   always_comb begin
      state_in  = state_ff;
      tot_ready = 1'b0;
      start     = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         erls_pkg::BK_IDLE: begin
            tot_ready = 1'b1;
            if (tot_valid) state_in = erls_pkg::BK_DIV;
         end
         erls_pkg::BK_DIV: begin
            start    = 1'b1;
            state_in = erls_pkg::BK_DONE;
         end
         erls_pkg::BK_DONE: begin
            rsp_valid = !(|busy);
            if (rsp_valid && rsp_ready) state_in = erls_pkg::BK_IDLE;
         end
         default: state_in = erls_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= erls_pkg::BK_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (tot_valid && tot_ready) begin
         t_ff    <= tot_data;
         meas_ff <= (tot_data.in_cnt != '0) && (tot_data.out_cnt != '0);
      end
   end

   always_comb begin
      logic [16:0] sf, bf;
      sf = 17'(q2);
      bf = 17'(q3);
      rsp_data = '0;
      if (meas_ff) begin
         rsp_data.measured            = 1'b1;
         rsp_data.subject_pixels      = t_ff.in_cnt;
         rsp_data.backdrop_pixels     = t_ff.out_cnt;
         rsp_data.subject_mean        = 22'(q0);
         rsp_data.subject_max         = t_ff.in_peak;
         rsp_data.subject_unlit_frac  = sf;
         rsp_data.backdrop_mean       = 22'(q1);
         rsp_data.backdrop_unlit_frac = bf;
         rsp_data.silhouette = ({1'b0, sf} >= {1'b0, bf} + {1'b0, excess_share}) &&
                               (18'h10000 - {1'b0, bf} >= {1'b0, backlit_share});
      end
   end
endmodule

>>> rtl/core/elliptical_region_luma_stats.sv
// Path: a pixel crosses the stage 1 and 2 registers into the accumulators; with the
// back end idle, an end_of_frame's totals start its 46-step dividers and rsp_valid
// rises once they finish. Throughput: one pixel per cycle; input pauses while an
// end_of_frame is in stage 1 or 2, stalls while a finished frame waits on a busy back
// end, else streams during divides. Reset (synchronous, active high) clears position,
// accumulators, handshakes and restores the register defaults.
module elliptical_region_luma_stats #(
   parameter int MAX_EDGE  = erls_pkg::MAX_EDGE_DEF,
   parameter int FRAC_BITS = erls_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  erls_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output erls_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [erls_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [erls_pkg::CSR_DAT_W-1:0]      csr_data
);
   logic signed [21:0] center_x_ff, center_y_ff;
   logic [23:0]        inv_rx_ff, inv_ry_ff;
   logic [21:0]        lit_th_ff;
   logic [16:0]        excess_ff, backlit_ff;
   logic               tot_valid, tot_ready;
   erls_pkg::totals_type tot_data;

   // register file: always ready, one write per transfer
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0; center_y_ff <= '0;
         inv_rx_ff <= '0; inv_ry_ff <= '0; lit_th_ff <= '0;
         excess_ff <= 17'd32768; backlit_ff <= 17'd32768;
      end else if (csr_valid) begin
         case (csr_index)
            erls_pkg::CSR_CENTER_X: center_x_ff <= csr_data[21:0];
            erls_pkg::CSR_CENTER_Y: center_y_ff <= csr_data[21:0];
            erls_pkg::CSR_INV_RX:   inv_rx_ff   <= csr_data;
            erls_pkg::CSR_INV_RY:   inv_ry_ff   <= csr_data;
            erls_pkg::CSR_LIT_TH:   lit_th_ff   <= csr_data[21:0];
            erls_pkg::CSR_EXCESS:   excess_ff   <= csr_data[16:0];
            erls_pkg::CSR_BACKLIT:  backlit_ff  <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // front: luma, ellipse test, accumulation; holds one finished frame
   erls_front #(.MAX_EDGE(MAX_EDGE), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .center_x(center_x_ff), .center_y(center_y_ff),
      .inv_rx(inv_rx_ff), .inv_ry(inv_ry_ff), .lit_th(lit_th_ff),
      .tot_valid, .tot_ready, .tot_data);

   // back: four serial dividers and the verdict
   erls_back u_back (
      .clock, .reset, .tot_valid, .tot_ready, .tot_data,
      .excess_share(excess_ff), .backlit_share(backlit_ff),
      .rsp_valid, .rsp_ready, .rsp_data);

   // an unmeasured result carries all-zero figures
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.measured |-> rsp_data.subject_pixels == '0 &&
      !rsp_data.silhouette)
      else $error("unmeasured result has nonzero fields");
   // a measured result has both sides populated
   a_meas: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.measured |-> rsp_data.subject_pixels != '0 &&
      rsp_data.backdrop_pixels != '0)
      else $error("measured result with empty side");
   // the mean never exceeds the peak
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.measured |-> rsp_data.subject_mean <= rsp_data.subject_max)
      else $error("subject mean above peak");
endmodule

>>> dv/erls_checker.sv
module erls_checker
   import erls_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  req_type                 req_data,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  rsp_type                 rsp_data,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DAT_W-1:0]    csr_data,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint CNT_MAX = (64'd1 << CNT_W) - 1;
   localparam longint SUM_MAX = (64'd1 << SUM_W) - 1;
   localparam longint ONE_Q32 = 64'd1 << 32;

   // shadow registers
   longint cx, cy;
   longint inv_rx, inv_ry, lit_th, excess, backlit;
   // frame accumulators
   longint col, row, in_cnt, out_cnt, in_sum, out_sum, in_peak, in_unlit, out_unlit;

   rsp_type stats_q[$];

   function automatic longint norm_offset(longint pos, longint ctr, longint inv);
      longint d;
      longint o;
      d = pos * 256 + 128 - ctr;
      if (d < 0) d = -d;
      o = d * inv;
      return (o > ONE_Q32) ? ONE_Q32 + 1 : o;
   endfunction

   function automatic longint sat_add(longint v, longint a, longint cap);
      return (v + a > cap) ? cap : v + a;
   endfunction

   task automatic clear_frame();
      col = 0; row = 0; in_cnt = 0; out_cnt = 0; in_sum = 0; out_sum = 0;
      in_peak = 0; in_unlit = 0; out_unlit = 0;
   endtask

   task automatic report(string what, longint got, longint want);
      $display("erls_checker: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic predict_pixel(req_type px);
      longint luma, ox, oy, tx, ty;
      longint sf, bf;
      bit     is_in;
      rsp_type r;
      luma = 2126 * px.red + 7152 * px.green + 722 * px.blue;
      ox = norm_offset(col, cx, inv_rx);
      oy = norm_offset(row, cy, inv_ry);
      is_in = 0;
      if (ox <= ONE_Q32 && oy <= ONE_Q32) begin
         tx = ox >> 16;
         ty = oy >> 16;
         is_in = (tx * tx + ty * ty) <= ONE_Q32;
      end
      if (is_in) begin
         in_cnt = sat_add(in_cnt, 1, CNT_MAX);
         in_sum = sat_add(in_sum, luma, SUM_MAX);
         if (luma > in_peak) in_peak = luma;
         if (luma <= lit_th) in_unlit = sat_add(in_unlit, 1, CNT_MAX);
      end else begin
         out_cnt = sat_add(out_cnt, 1, CNT_MAX);
         out_sum = sat_add(out_sum, luma, SUM_MAX);
         if (luma <= lit_th) out_unlit = sat_add(out_unlit, 1, CNT_MAX);
      end
      if (!px.end_of_frame) begin
         if (px.end_of_line) begin
            col = 0;
            if (row + 1 < MAX_EDGE_DEF) row++;
         end else if (col + 1 < MAX_EDGE_DEF) begin
            col++;
         end
      end else begin
         r = '0;
         if (in_cnt > 0 && out_cnt > 0) begin
            sf = (in_unlit << 16) / in_cnt;
            bf = (out_unlit << 16) / out_cnt;
            r.measured            = 1'b1;
            r.subject_pixels      = CNT_W'(in_cnt);
            r.backdrop_pixels     = CNT_W'(out_cnt);
            r.subject_mean        = LUMA_W'(in_sum / in_cnt);
            r.subject_max         = LUMA_W'(in_peak);
            r.subject_unlit_frac  = FRAC_W'(sf);
            r.backdrop_mean       = LUMA_W'(out_sum / out_cnt);
            r.backdrop_unlit_frac = FRAC_W'(bf);
            r.silhouette = (sf >= bf + excess) && (65536 - bf >= backlit);
         end
         stats_q.push_back(r);
         clear_frame();
      end
   endtask

   task automatic compare_stats(rsp_type got);
      rsp_type w;
      if (stats_q.size() == 0) begin
         report("unexpected result", 1, 0);
         return;
      end
      w = stats_q.pop_front();
      if (got.measured != w.measured) report("measured", got.measured, w.measured);
      if (got.subject_pixels != w.subject_pixels)
         report("subject_pixels", got.subject_pixels, w.subject_pixels);
      if (got.backdrop_pixels != w.backdrop_pixels)
         report("backdrop_pixels", got.backdrop_pixels, w.backdrop_pixels);
      if (got.subject_mean != w.subject_mean)
         report("subject_mean", got.subject_mean, w.subject_mean);
      if (got.subject_max != w.subject_max)
         report("subject_max", got.subject_max, w.subject_max);
      if (got.subject_unlit_frac != w.subject_unlit_frac)
         report("subject_unlit_frac", got.subject_unlit_frac, w.subject_unlit_frac);
      if (got.backdrop_mean != w.backdrop_mean)
         report("backdrop_mean", got.backdrop_mean, w.backdrop_mean);
      if (got.backdrop_unlit_frac != w.backdrop_unlit_frac)
         report("backdrop_unlit_frac", got.backdrop_unlit_frac, w.backdrop_unlit_frac);
      if (got.silhouette != w.silhouette)
         report("silhouette", got.silhouette, w.silhouette);
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cx = 0; cy = 0; inv_rx = 0; inv_ry = 0; lit_th = 0;
         excess = 32768; backlit = 32768;
         clear_frame();
         stats_q.delete();
      end else begin
         // results first: a config write never lands mid-frame in this bench
         if (rsp_valid && rsp_ready) compare_stats(rsp_data);
         if (req_valid && req_ready) predict_pixel(req_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_X: cx = longint'($signed(csr_data[21:0]));
               CSR_CENTER_Y: cy = longint'($signed(csr_data[21:0]));
               CSR_INV_RX:   inv_rx = longint'(csr_data[23:0]);
               CSR_INV_RY:   inv_ry = longint'(csr_data[23:0]);
               CSR_LIT_TH:   lit_th = longint'(csr_data[21:0]);
               CSR_EXCESS:   excess = longint'(csr_data[16:0]);
               CSR_BACKLIT:  backlit = longint'(csr_data[16:0]);
               default: ;
            endcase
         end
      end
      pending <= stats_q.size();
   end

   final begin
      if (stats_q.size() != 0) $display("erls_checker: %0d results missing", stats_q.size());
   end
endmodule

>>> dv/tb_top.sv
module tb_top;
   import erls_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;
   int fail_count, pending;
   int cycles;
   int idle_pct;        // percent of cycles each side idles; 0 during quiet stretch
   bit hold_off;        // long receiver stall for backpressure

   localparam int CYCLE_LIMIT = 400000;

   elliptical_region_luma_stats dut (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   erls_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus an optional long hold-off
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         rsp_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
      end
   end

   // one pixel transfer, with random idle cycles before it; valid stays up after
   // the transfer so the next pixel can follow at once, drain() drops it
   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             bit eol, bit eof);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data  <= '{red: r, green: g, blue: b, end_of_line: eol, end_of_frame: eof};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // wait until every frame result has come back, then let the back end drain
   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (pending != 0);
      repeat (80) @(negedge clock);
   endtask

   // frame of w x h pixels; mode 0 random, 1 dark, 2 white, 3 dark subject/bright backdrop
   task automatic send_frame(int w, int h, int mode);
      logic [7:0] r, g, b;
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            case (mode)
               1: begin r = 0; g = 0; b = 0; end
               2: begin r = 8'hff; g = 8'hff; b = 8'hff; end
               3: begin
                  r = (x > 0 && x < w-1 && y > 0 && y < h-1) ? 8'd3 : 8'hf0;
                  g = r; b = r;
               end
               default: begin
                  r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
               end
            endcase
            send_pixel(r, g, b, (x == w-1) && (y != h-1), (x == w-1) && (y == h-1));
         end
      end
   endtask

   // ellipse roughly centered in a w x h frame
   task automatic set_ellipse(int w, int h, int rx, int ry);
      write_reg(CSR_CENTER_X, 24'(w * 128));
      write_reg(CSR_CENTER_Y, 24'(h * 128));
      write_reg(CSR_INV_RX, 24'((1 << 24) / rx));
      write_reg(CSR_INV_RY, 24'((1 << 24) / ry));
   endtask

   int n_items;
   int w, h;
   int phase, reps;

   initial begin
      reset = 1;
      req_valid = 0; req_data = '0;
      csr_valid = 0; csr_index = '0; csr_data = '0;
      idle_pct = 23; hold_off = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: default registers (zero inverse radii means every pixel inside -> unmeasured)
      send_frame(2, 1, 0);
      send_pixel(0, 0, 0, 0, 1);                  // single pixel frame
      drain();
      // extremes of color, a silhouette-shaped frame
      set_ellipse(4, 4, 2, 2);
      write_reg(CSR_LIT_TH, 24'd100000);
      write_reg(CSR_EXCESS, 24'd0);
      write_reg(CSR_BACKLIT, 24'd0);
      send_frame(4, 4, 3);
      send_frame(3, 2, 2);
      send_frame(3, 2, 1);
      // end of frame without end of line mid-row
      send_pixel(8'hff, 0, 0, 0, 0);
      send_pixel(0, 8'hff, 0, 0, 0);
      send_pixel(0, 0, 8'hff, 0, 1);
      drain();
      // far-off, negative center and shares of one and beyond
      write_reg(CSR_CENTER_X, 24'h200000);        // most negative
      write_reg(CSR_CENTER_Y, 24'h1fffff);        // most positive
      write_reg(CSR_INV_RX, 24'hffffff);
      write_reg(CSR_INV_RY, 24'hffffff);
      write_reg(CSR_LIT_TH, 24'd2550000);
      write_reg(CSR_EXCESS, 24'h1ffff);
      write_reg(CSR_BACKLIT, 24'd65536);
      send_frame(3, 2, 0);
      drain();

      // random phases: ~600 pixels in small frames, several register settings
      n_items = 0;
      phase = 0;
      while (n_items < 600) begin
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 6);
         if ($urandom_range(3) == 0) begin
            // arbitrary register values, extremes included
            write_reg(CSR_CENTER_X, 24'($urandom));
            write_reg(CSR_CENTER_Y, 24'($urandom));
            write_reg(CSR_INV_RX, $urandom_range(1) ? 24'($urandom) : 24'(0));
            write_reg(CSR_INV_RY, 24'($urandom));
         end else begin
            set_ellipse(w, h, $urandom_range(1, 5), $urandom_range(1, 4));
         end
         write_reg(CSR_LIT_TH, 24'($urandom_range(2550000)));
         write_reg(CSR_EXCESS,
                   $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(65536)));
         write_reg(CSR_BACKLIT, 24'($urandom_range(65536)));
         // phases 1 and 2 run with no idling; phase 2 also holds off the receiver
         idle_pct = (phase == 1 || phase == 2) ? 0 : 23;
         reps = (phase == 2) ? 4 : $urandom_range(1, 4);
         if (phase == 2) begin
            fork
               begin
                  hold_off = 1;
                  repeat (400) @(negedge clock);
                  hold_off = 0;
               end
            join_none
         end
         repeat (reps) begin
            send_frame(w, h, $urandom_range(3));
            n_items += w * h;
         end
         // a stray pixel stream ending with end_of_frame alone
         if ($urandom_range(7) == 0) begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 0);
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 0, 1);
            n_items += 2;
         end
         drain();
         phase++;
      end

      idle_pct = 0;
      drain();
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule
